@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files. They vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/ndt_pkg.sv @@
`timescale 1ns / 1ps
package ndt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 16;
  localparam int AMOUNT_W = 31;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW   = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [HANDLE_W-1:0] handle;
    logic [AMOUNT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] drawn_handle;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [AMOUNT_W-1:0] amount;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the closest-value tracker.
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // Running winner of a draw scan.
  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [HANDLE_W-1:0] handle;
  } best_t;

endpackage

@@ rtl/core/nearest_value_draw_table.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Payload  Handshake
// req      in         req_t    req_valid / req_stall
// rsp      out        rsp_t    rsp_valid / rsp_stall
//
// One request at a time. Insert, an empty draw and an unused code go straight to finish.
// A drop makes one compaction pass and a draw a scan pass then a compaction pass; each
// entry is read once per pass through the single read port of the table memory.
// After reset the table is empty; no memory clearing pass is needed.
// A stalled response holds the finished result; the next request waits for it to leave.
`include "assert_macros.svh"
module nearest_value_draw_table import ndt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_COMPACT = 3'd2;
  localparam logic [2:0] S_FINISH  = 3'd3;

  logic [2:0]          state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    wr_ptr;
  logic                v1;
  logic [IDX_W-1:0]    idx1;
  req_t                req_q;
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;

  logic                req_take;
  logic                issue;
  logic                keep;
  logic                compact_end;
  logic                rsp_load;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_ent;
  logic [ENTRY_W-1:0]  rd_raw;
  entry_t              rd_ent;
  scan_ctl_t           ctl;
  best_t               best;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && (state == S_IDLE);
  assign issue     = ((state == S_SCAN) || (state == S_COMPACT)) && (rd_ptr < count);
  assign rd_ent    = entry_t'(rd_raw);

  // The drawn entry is skipped by position; a drop skips every matching handle.
  assign keep = (req_q.operation == OP_DRAW) ? (idx1 != best.idx)
                                             : (rd_ent.handle != req_q.handle);
  assign compact_end = (state == S_COMPACT) && !issue && !v1;

  // A finished result moves into the output register once the old beat has left.
  assign rsp_load = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_ptr[IDX_W-1:0];
    wr_ent  = rd_ent;
    if (req_take && (req.operation == OP_INSERT) && (count != CNT_W'(TABLE_DEPTH))) begin
      wr_en   = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_ent  = '{handle: req.handle, amount: req.amount};
    end else if ((state == S_COMPACT) && v1 && keep) begin
      wr_en = 1'b1;
    end
  end

  assign ctl = '{clear: req_take, valid: v1 && (state == S_SCAN), idx: idx1};

  ndt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (rd_ptr[IDX_W-1:0]),
    .rd_data (rd_raw)
  );

  ndt_best u_best (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .ent    (rd_ent),
    .target (req_q.amount),
    .best   (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      v1        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      v1 <= issue;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            rd_ptr     <= '0;
            wr_ptr     <= '0;
            res_handle <= '0;
            case (req.operation)
              OP_INSERT: begin
                state <= S_FINISH;
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_DONE;
                  count      <= count + 1'b1;
                end
              end
              OP_DRAW: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FINISH;
                end else begin
                  res_status <= ST_DONE;
                  state      <= S_SCAN;
                end
              end
              OP_DROP: begin
                res_status <= ST_DONE;
                state      <= S_COMPACT;
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end else if (!v1) begin
            rd_ptr <= '0;
            state  <= S_COMPACT;
          end
        end
        S_COMPACT: begin
          if (issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (v1 && keep) begin
            wr_ptr <= wr_ptr + 1'b1;
          end
          if (compact_end) begin
            count <= wr_ptr;
            if (req_q.operation == OP_DRAW) begin
              res_handle <= best.handle;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
    if (issue) begin
      idx1 <= rd_ptr[IDX_W-1:0];
    end
    if (rsp_load) begin
      rsp <= '{status: res_status, drawn_handle: res_handle,
               entry_count: COUNT_W'(count)};
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH))
  `ASSERT_IMPLIES(a_write_behind_read, clk, rst, (state == S_COMPACT) && wr_en,
                  wr_ptr[IDX_W-1:0] <= idx1)
  `ASSERT_IMPLIES(a_draw_removes_one, clk, rst,
                  compact_end && (req_q.operation == OP_DRAW),
                  best.found && (wr_ptr == count - 1'b1))
  `ASSERT_NEXT(a_full_insert_keeps_count, clk, rst,
               req_take && (req.operation == OP_INSERT) && (count == CNT_W'(TABLE_DEPTH)),
               count == $past(count))

endmodule

@@ rtl/core/ndt_ram.sv @@
`timescale 1ns / 1ps
module ndt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/ndt_best.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ndt_best import ndt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  scan_ctl_t           ctl,
  input  entry_t              ent,
  input  logic [AMOUNT_W-1:0] target,
  output best_t               best
);

  logic                s_valid;
  logic [IDX_W-1:0]    s_idx;
  logic [HANDLE_W-1:0] s_handle;
  logic [AMOUNT_W-1:0] s_diff;
  logic [AMOUNT_W-1:0] best_diff;
  logic [AMOUNT_W:0]   up_diff;
  logic [AMOUNT_W:0]   down_diff;
  logic                take;

  // Both differences are formed at once; the borrow of one picks the other.
  assign up_diff   = {1'b0, ent.amount} - {1'b0, target};
  assign down_diff = {1'b0, target} - {1'b0, ent.amount};

  // Strict less-than keeps the earliest entry on a tie.
  assign take = s_valid && (!best.found || (s_diff < best_diff));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      s_valid    <= 1'b0;
      best.found <= 1'b0;
    end else begin
      s_valid <= ctl.valid;
      if (take) begin
        best.found <= 1'b1;
      end
    end
    if (ctl.valid) begin
      s_idx    <= ctl.idx;
      s_handle <= ent.handle;
      s_diff   <= up_diff[AMOUNT_W] ? down_diff[AMOUNT_W-1:0] : up_diff[AMOUNT_W-1:0];
    end
    if (take) begin
      best.idx    <= s_idx;
      best.handle <= s_handle;
      best_diff   <= s_diff;
    end
  end

  `ASSERT_NEXT(a_best_found_sticky, clk, rst, best.found && !ctl.clear, best.found)
  `ASSERT_NEXT(a_take_sets_found, clk, rst, take && !ctl.clear, best.found)
  `ASSERT_NEXT(a_diff_never_grows, clk, rst, best.found && !ctl.clear,
               best_diff <= $past(best_diff))

endmodule
